// File: sv/bea_pkg.sv
package bea_pkg;

    localparam int BTN_W    = 8;
    localparam int TIMER_W  = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int QUERY_W  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_DIVISOR = 1'b1;

    localparam logic [CFG_W-1:0] RESET_REPEAT_DELAY  = 8'd15;
    localparam logic [CFG_W-1:0] RESET_FRAME_DIVISOR = 8'b00000001;

    localparam int QF_ALL_PRESSED   = 0;
    localparam int QF_ALL_RELEASED  = 1;
    localparam int QF_ALL_HELD      = 2;
    localparam int QF_ALL_REPEAT    = 3;
    localparam int QF_ALL_GREPEAT   = 4;
    localparam int QF_ALL_GDELAYED  = 5;
    localparam int QF_ANY_PRESSED   = 6;
    localparam int QF_ANY_REPEAT    = 7;
    localparam int QF_ANY_GREPEAT   = 8;
    localparam int QF_ANY_GDELAYED  = 9;

    typedef struct packed {
        logic repeating;
        logic delayed;
    } t_btn_flags;

endpackage

// File: sv/bea_button.sv
module bea_button
    import bea_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_held,
    input  logic               i_released,
    input  logic [CFG_W-1:0]   i_repeat_delay,
    output t_btn_flags         o_flags
);

    logic [TIMER_W-1:0] r_hold;
    logic [TIMER_W-1:0] n_hold;
    logic [TIMER_W-1:0] r_phase;
    logic [TIMER_W-1:0] n_phase;
    logic [TIMER_W-1:0] phase_inc;
    logic [TIMER_W-1:0] delay_m1;

    assign phase_inc = r_phase + TIMER_W'(1);
    assign delay_m1  = i_repeat_delay - CFG_W'(1);

    always_comb begin
        n_hold  = r_hold;
        n_phase = r_phase;
        if (i_held) begin
            if (r_hold < i_repeat_delay) begin
                n_hold = r_hold + TIMER_W'(1);
            end
            if (n_hold >= i_repeat_delay) begin
                n_phase = (phase_inc >= i_repeat_delay) ? '0 : phase_inc;
            end
        end
        if (i_released) begin
            n_hold  = '0;
            n_phase = '0;
        end
        o_flags.repeating = (n_hold >= i_repeat_delay);
        o_flags.delayed   = (n_phase == delay_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= '0;
            r_phase <= '0;
        end else if (i_advance) begin
            r_hold  <= n_hold;
            r_phase <= n_phase;
        end
    end

endmodule

// File: sv/button_edge_autorepeat.sv
// an accepted input beat is registered in the input stage, and its result beat in the result register
// throughput: one beat per cycle while m_axis_tready does not stall the output, set by the per-button timer update
// the output register is refilled in the cycle it is taken, so no bubbles under flow
// reset (synchronous, active low): timers, sample history and frame counters clear,
// repeat_delay returns to 15 and frame_divisor to 1
module button_edge_autorepeat
    import bea_pkg::*;
#(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // buttons[7:0], check_mask[15:8]
    input  logic [15:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pressed[7:0], released[15:8], held[23:16], repeating[31:24],
    // delayed_repeat[39:32], frame_gate[40], query_flags[50:41], zero[55:51]
    output logic [55:0]          m_axis_tdata
);

    localparam int NB = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;
    localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((1 << NB) - 1);

    logic [CFG_W-1:0] r_repeat_delay;
    logic [CFG_W-1:0] r_frame_divisor;

    logic             r_in_valid;
    logic [BTN_W-1:0] r_in_buttons;
    logic [BTN_W-1:0] r_in_check;

    logic             r_out_valid;
    logic [55:0]      r_out_data;

    logic [BTN_W-1:0] r_prev;
    logic [7:0]       r_frame_count;
    logic [7:0]       r_div_phase;
    logic [7:0]       n_frame_count;
    logic [7:0]       n_div_phase;
    logic [8:0]       div_inc;

    logic             out_ready;
    logic             advance;
    logic [BTN_W-1:0] cur;
    logic [BTN_W-1:0] held;
    logic [BTN_W-1:0] rel;
    logic [BTN_W-1:0] prs;
    logic [BTN_W-1:0] rep;
    logic [BTN_W-1:0] dly;
    logic             gate;
    logic [QUERY_W-1:0] query;

    t_btn_flags       flags [NB];

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_delay  <= RESET_REPEAT_DELAY;
            r_frame_divisor <= RESET_FRAME_DIVISOR;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_REPEAT_DELAY:  r_repeat_delay  <= i_cfg_wdata;
                REG_FRAME_DIVISOR: r_frame_divisor <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_buttons <= s_axis_tdata[7:0];
            r_in_check   <= s_axis_tdata[15:8];
        end
    end

    assign cur  = r_in_buttons & BTN_MASK;
    assign held = r_prev & cur;
    assign rel  = r_prev & ~cur;
    assign prs  = cur & ~r_prev;

    // frame gate
    assign n_frame_count = r_frame_count + 8'd1;
    assign div_inc       = {1'b0, r_div_phase} + 9'd1;

    always_comb begin
        if (n_frame_count == 8'd0) begin
            n_div_phase = '0;
        end else if (div_inc >= {1'b0, r_frame_divisor}) begin
            n_div_phase = '0;
        end else begin
            n_div_phase = div_inc[7:0];
        end
    end

    assign gate = (n_div_phase == 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_frame_count <= '0;
            r_div_phase   <= '0;
        end else if (advance) begin
            r_prev        <= cur;
            r_frame_count <= n_frame_count;
            r_div_phase   <= n_div_phase;
        end
    end

    // per-button timers
    genvar b;
    generate
        for (b = 0; b < NB; b++) begin : g_btn
            bea_button u_btn (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_advance      (advance),
                .i_held         (held[b]),
                .i_released     (rel[b]),
                .i_repeat_delay (r_repeat_delay),
                .o_flags        (flags[b])
            );
        end
    endgenerate

    always_comb begin
        rep = '0;
        dly = '0;
        for (int i = 0; i < NB; i++) begin
            rep[i] = flags[i].repeating;
            dly[i] = flags[i].delayed;
        end
    end

    // query flags
    always_comb begin
        query = '0;
        query[QF_ALL_PRESSED]  = ((prs  & r_in_check) == r_in_check);
        query[QF_ALL_RELEASED] = ((rel  & r_in_check) == r_in_check);
        query[QF_ALL_HELD]     = ((held & r_in_check) == r_in_check);
        query[QF_ALL_REPEAT]   = ((rep  & r_in_check) == r_in_check);
        query[QF_ALL_GREPEAT]  = gate && query[QF_ALL_REPEAT];
        query[QF_ALL_GDELAYED] = gate && ((dly & r_in_check) == r_in_check);
        query[QF_ANY_PRESSED]  = ((prs & r_in_check) != '0);
        query[QF_ANY_REPEAT]   = ((rep & r_in_check) != '0);
        query[QF_ANY_GREPEAT]  = gate && query[QF_ANY_REPEAT];
        query[QF_ANY_GDELAYED] = gate && ((dly & r_in_check) != '0);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {5'd0, query, gate, dly, rep, held, rel, prs};
        end
    end

endmodule

// File: tb/sv/tb_button_edge_autorepeat.sv
`timescale 1ns / 100ps

module tb_button_edge_autorepeat;
    import bea_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [4:0]       pad;
        logic [QUERY_W-1:0] query;
        logic             gate;
        logic [BTN_W-1:0] delayed;
        logic [BTN_W-1:0] repeating;
        logic [BTN_W-1:0] held;
        logic [BTN_W-1:0] released;
        logic [BTN_W-1:0] pressed;
    } t_frame_result;

    class frame_scoreboard;
        logic [CFG_W-1:0]   rpt_delay;
        logic [CFG_W-1:0]   frm_div;
        logic [BTN_W-1:0]   prev_btns;
        logic [7:0]         frame_cnt;
        logic [7:0]         div_phase;
        logic [TIMER_W-1:0] hold_tmr [BTN_W];
        logic [TIMER_W-1:0] rpt_phase [BTN_W];
        t_frame_result      expected_q [$];
        int                 errors;

        function new();
            rpt_delay = RESET_REPEAT_DELAY;
            frm_div   = RESET_FRAME_DIVISOR;
            prev_btns = '0;
            frame_cnt = '0;
            div_phase = '0;
            errors    = 0;
            for (int b = 0; b < BTN_W; b++) begin
                hold_tmr[b]  = '0;
                rpt_phase[b] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_REPEAT_DELAY:  rpt_delay = val;
                REG_FRAME_DIVISOR: frm_div = val;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [BTN_W-1:0] btn, logic [BTN_W-1:0] chk);
            t_frame_result r;
            logic [BTN_W-1:0] dly_cmp;
            logic [8:0] nxt;
            r = '0;
            r.held     = prev_btns & btn;
            r.released = prev_btns & ~btn;
            r.pressed  = btn & ~prev_btns;
            dly_cmp    = rpt_delay - 8'd1;

            frame_cnt = frame_cnt + 8'd1;
            if (frame_cnt == 8'd0) begin
                div_phase = '0;
            end else begin
                nxt = {1'b0, div_phase} + 9'd1;
                div_phase = (nxt >= {1'b0, frm_div}) ? 8'd0 : nxt[7:0];
            end
            r.gate = (div_phase == 8'd0);

            for (int b = 0; b < BTN_W; b++) begin
                if (r.held[b]) begin
                    if (hold_tmr[b] < rpt_delay) hold_tmr[b] = hold_tmr[b] + 8'd1;
                    if (hold_tmr[b] >= rpt_delay) begin
                        rpt_phase[b] = rpt_phase[b] + 8'd1;
                        if (rpt_phase[b] >= rpt_delay) rpt_phase[b] = '0;
                    end
                end
                if (r.released[b]) begin
                    hold_tmr[b]  = '0;
                    rpt_phase[b] = '0;
                end
                r.repeating[b] = (hold_tmr[b] >= rpt_delay);
                r.delayed[b]   = (rpt_phase[b] == dly_cmp);
            end
            prev_btns = btn;

            r.query[QF_ALL_PRESSED]  = ((r.pressed & chk) == chk);
            r.query[QF_ALL_RELEASED] = ((r.released & chk) == chk);
            r.query[QF_ALL_HELD]     = ((r.held & chk) == chk);
            r.query[QF_ALL_REPEAT]   = ((r.repeating & chk) == chk);
            r.query[QF_ALL_GREPEAT]  = r.gate && ((r.repeating & chk) == chk);
            r.query[QF_ALL_GDELAYED] = r.gate && ((r.delayed & chk) == chk);
            r.query[QF_ANY_PRESSED]  = ((r.pressed & chk) != 0);
            r.query[QF_ANY_REPEAT]   = ((r.repeating & chk) != 0);
            r.query[QF_ANY_GREPEAT]  = r.gate && ((r.repeating & chk) != 0);
            r.query[QF_ANY_GDELAYED] = r.gate && ((r.delayed & chk) != 0);
            expected_q.push_back(r);
        endfunction

        function void match(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_beat(logic [55:0] beat);
            t_frame_result want;
            t_frame_result got;
            got = beat;
            if (expected_q.size() == 0) begin
                $error("result beat 0x%0h with nothing expected", beat);
                errors++;
            end else begin
                want = expected_q.pop_front();
                match("pressed_mask", want.pressed, got.pressed);
                match("released_mask", want.released, got.released);
                match("held_mask", want.held, got.held);
                match("repeating_mask", want.repeating, got.repeating);
                match("delayed_repeat_mask", want.delayed, got.delayed);
                match("frame_gate", want.gate, got.gate);
                match("query_flags", want.query, got.query);
                match("zero_pad", want.pad, got.pad);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // buttons[7:0], check_mask[15:8]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // pressed[7:0], released[15:8], held[23:16], repeating[31:24],
    // delayed_repeat[39:32], frame_gate[40], query_flags[50:41], zero[55:51]
    logic [55:0]          m_axis_tdata;

    frame_scoreboard frames = new();
    int  src_idle_pct;
    int  sink_idle_pct;
    bit  sink_held;
    int  cycles;

    button_edge_autorepeat i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(negedge i_clk) begin
        if (sink_held) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            frames.check_beat(m_axis_tdata);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_sample(input logic [BTN_W-1:0] btn, input logic [BTN_W-1:0] chk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {chk, btn};
        do @(posedge i_clk); while (!s_axis_tready);
        frames.note_sample(btn, chk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (frames.pending() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        frames.write_reg(idx, val);
    endtask

    task automatic hold_sink(input int n);
        @(posedge i_clk);
        sink_held = 1'b1;
        repeat (n) @(posedge i_clk);
        sink_held = 1'b0;
    endtask

    initial begin
        logic [BTN_W-1:0] btn;
        logic [BTN_W-1:0] chk;
        logic [CFG_W-1:0] dly;
        logic [CFG_W-1:0] div;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        sink_held     = 1'b0;
        cycles        = 0;
        src_idle_pct  = 37;
        sink_idle_pct = 83;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, empty check mask
        send_sample(8'h00, 8'h00);
        send_sample(8'hFF, 8'h00);

        set_reg(REG_REPEAT_DELAY, 8'd3);
        set_reg(REG_FRAME_DIVISOR, 8'd3);
        send_sample(8'h00, 8'hFF);
        repeat (5) send_sample(8'hFF, 8'hFF);
        send_sample(8'h00, 8'hFF);
        send_sample(8'hAA, 8'h55);
        send_sample(8'h55, 8'hAA);
        send_sample(8'h80, 8'h80);
        send_sample(8'h01, 8'h01);

        // delay of one
        set_reg(REG_REPEAT_DELAY, 8'd1);
        repeat (3) send_sample(8'hFF, 8'hFF);

        // zero delay and zero divisor
        set_reg(REG_REPEAT_DELAY, 8'd0);
        set_reg(REG_FRAME_DIVISOR, 8'd0);
        repeat (2) send_sample(8'h0F, 8'h0F);
        send_sample(8'h00, 8'h0F);

        // timers above a lowered delay
        set_reg(REG_REPEAT_DELAY, 8'd12);
        set_reg(REG_FRAME_DIVISOR, 8'd255);
        repeat (6) send_sample(8'hF0, 8'hF0);
        set_reg(REG_REPEAT_DELAY, 8'd4);
        repeat (2) send_sample(8'hF0, 8'hC0);
        set_reg(REG_REPEAT_DELAY, 8'd255);
        send_sample(8'hF0, 8'h30);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 37 : (ph == 1) ? 83 : 0;
            sink_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 37 : 0;
            for (int seg = 0; seg < 6; seg++) begin
                case ($urandom_range(9))
                    0:       dly = 8'd0;
                    1:       dly = 8'd255;
                    2:       dly = 8'd1;
                    3:       dly = CFG_W'($urandom_range(255));
                    default: dly = CFG_W'($urandom_range(10, 2));
                endcase
                case ($urandom_range(9))
                    0:       div = 8'd0;
                    1:       div = 8'd255;
                    2:       div = 8'd1;
                    3:       div = CFG_W'($urandom_range(255));
                    default: div = CFG_W'($urandom_range(8, 2));
                endcase
                set_reg(REG_REPEAT_DELAY, dly);
                set_reg(REG_FRAME_DIVISOR, div);
                if (ph == 2 && seg == 0) begin
                    fork
                        hold_sink(80);
                    join_none
                end
                btn = BTN_W'($urandom);
                repeat (30) begin
                    if ($urandom_range(9) == 0) begin
                        btn = BTN_W'($urandom);
                    end else begin
                        for (int b = 0; b < BTN_W; b++) begin
                            if ($urandom_range(5) == 0) btn[b] = ~btn[b];
                        end
                    end
                    case ($urandom_range(3))
                        0:       chk = BTN_W'($urandom);
                        1:       chk = btn;
                        2:       chk = 8'h01 << $urandom_range(BTN_W - 1);
                        default: chk = $urandom_range(1) ? 8'hFF : 8'h00;
                    endcase
                    send_sample(btn, chk);
                end
            end
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (frames.pending() != 0) begin
            $error("%0d expected results never arrived", frames.pending());
            frames.errors++;
        end
        if (frames.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
